### hdl/rdf_pkg.sv
// Shared codes, command and status types, and the digit weight function
// for the readout axis display formatter. No dependencies.
package rdf_pkg;

  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_BUTTON  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  localparam logic [1:0] CMD_POWER = 2'd0;
  localparam logic [1:0] CMD_FAST  = 2'd1;
  localparam logic [1:0] CMD_DIR   = 2'd2;
  localparam logic [1:0] CMD_ZERO  = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_POWER = 2'd1;
  localparam logic [1:0] ACT_FAST  = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  localparam logic [7:0]  DIGIT_ZERO  = 8'd48;
  localparam logic [7:0]  MINUS_SIGN  = 8'd45;
  localparam logic [7:0]  BLANK_RESET = 8'd32;
  localparam logic [16:0] SAT_LIMIT   = 17'd99999;
  localparam logic [2:0]  DIGIT_LAST  = 3'd4;
  localparam logic [2:0]  SHOW_FROM   = 3'd2;

  typedef struct packed {
    logic       raw_write;
    logic       load_button;
    logic       btn_exec;
    logic       start_display;
    logic       calc_value;
    logic       calc_mag;
    logic       digit_step;
    logic [2:0] digit_idx;
    logic       emit;
    logic       emit_button;
    logic [1:0] axis_idx;
    logic       last;
  } rdf_cmd_t;

  typedef struct packed {
    logic btn_hit;
    logic out_free;
  } rdf_status_t;

  function automatic logic [16:0] digit_weight(input logic [2:0] k, input logic [3:0] j);
    logic [16:0] w;
    case (k)
      3'd0: w = 17'(j) * 17'd10000;
      3'd1: w = 17'(j) * 17'd1000;
      3'd2: w = 17'(j) * 17'd100;
      3'd3: w = 17'(j) * 17'd10;
      default: w = 17'(j);
    endcase
    return w;
  endfunction

endpackage

### hdl/rdf_ctrl.sv
// Controller state machine of the readout axis display formatter.
// Depends on rdf_pkg; drives the datapath through rdf_cmd_t commands.
module rdf_ctrl import rdf_pkg::*; #(
  parameter int AXES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  rdf_status_t status,
  output rdf_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BTN   = 3'd1;
  localparam logic [2:0] S_VALUE = 3'd2;
  localparam logic [2:0] S_MAG   = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  logic [2:0] state, state_next;
  logic [2:0] dcnt, dcnt_next;
  logic [1:0] acnt, acnt_next;
  logic       is_button, is_button_next;

  always_comb begin
    state_next     = state;
    dcnt_next      = dcnt;
    acnt_next      = acnt;
    is_button_next = is_button;
    cmd            = '0;
    cmd.digit_idx  = dcnt;
    cmd.axis_idx   = acnt;
    cmd.emit_button = is_button;
    cmd.last       = is_button || (acnt == LAST_AXIS);
    in_ready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_RAW: begin
              cmd.raw_write = 1'b1;
            end
            OP_BUTTON: begin
              cmd.load_button = 1'b1;
              is_button_next  = 1'b1;
              state_next      = S_BTN;
            end
            OP_DISPLAY: begin
              cmd.start_display = 1'b1;
              is_button_next    = 1'b0;
              acnt_next         = '0;
              state_next        = S_VALUE;
            end
            default: begin
            end
          endcase
        end
      end
      S_BTN: begin
        cmd.btn_exec = 1'b1;
        state_next   = status.btn_hit ? S_EMIT : S_IDLE;
      end
      S_VALUE: begin
        cmd.calc_value = 1'b1;
        state_next     = S_MAG;
      end
      S_MAG: begin
        cmd.calc_mag = 1'b1;
        dcnt_next    = '0;
        state_next   = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.digit_step = 1'b1;
        if (dcnt == DIGIT_LAST) begin
          state_next = S_EMIT;
        end else begin
          dcnt_next = dcnt + 3'd1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (is_button || (acnt == LAST_AXIS)) begin
            state_next = S_IDLE;
          end else begin
            acnt_next  = acnt + 2'd1;
            state_next = S_VALUE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dcnt      <= '0;
      acnt      <= '0;
      is_button <= 1'b0;
    end else begin
      state     <= state_next;
      dcnt      <= dcnt_next;
      acnt      <= acnt_next;
      is_button <= is_button_next;
    end
  end

  a_digits_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && dcnt == DIGIT_LAST) |=> (state == S_EMIT))
    else $error("digit sequence did not end in the emit state");

  a_display_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_DISPLAY) |=> (state == S_VALUE && acnt == 2'd0))
    else $error("display request did not start at the first axis");

  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("controller did not return to idle after the final word");

endmodule

### hdl/rdf_datapath.sv
// Datapath of the readout axis display formatter: axis stores, value and
// digit formatting, and the output register. Depends on rdf_pkg.
module rdf_datapath import rdf_pkg::*; #(
  parameter int AXES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  rdf_cmd_t           cmd,
  output rdf_status_t        status,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic [1:0]         axis,
  input  logic signed [23:0] raw_sample,
  input  logic [15:0]        button_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_axis,
  output logic [1:0]         action,
  output logic signed [31:0] shown_value,
  output logic [7:0]         char_one,
  output logic [7:0]         char_two,
  output logic [7:0]         char_three,
  output logic [7:0]         char_four,
  output logic [7:0]         char_five,
  output logic [7:0]         char_six,
  output logic [3:0]         updated_mask,
  output logic               last
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [7:0]  blank;
  logic [23:0] raw_store [AXES];
  logic [31:0] offset_store [AXES];
  logic        dir_neg [AXES];
  logic [3:0]  update_flags;
  logic [3:0]  mask_r;

  logic [15:0] btn_bits_r;
  logic [3:0]  btn_low;
  logic [1:0]  btn_ax;
  logic [1:0]  btn_axis_r;
  logic [1:0]  btn_act_r;
  logic [1:0]  btn_act;
  logic        btn_hit;
  logic [31:0] btn_twice;

  logic [31:0] val_r;
  logic [31:0] raw_ext;
  logic [31:0] abs_val;
  logic        neg_r;
  logic [16:0] mag_rem;
  logic        started;
  logic [2:0]  sign_pos;
  logic [7:0]  digs [5];
  logic [3:0]  digit;
  logic [16:0] digit_sub;
  logic        start_now;
  logic [AW-1:0] ai;

  always_comb begin
    btn_low = '0;
    for (int i = 15; i >= 0; i--) begin
      if (btn_bits_r[i]) begin
        btn_low = 4'(i);
      end
    end
  end

  assign btn_ax    = btn_low[3:2];
  assign btn_hit   = (btn_bits_r != 16'd0) && (int'(btn_ax) < AXES);
  assign btn_twice = {{8{raw_store[btn_ax[AW-1:0]][23]}}, raw_store[btn_ax[AW-1:0]]} << 1;

  always_comb begin
    case (btn_low[1:0])
      CMD_POWER: btn_act = ACT_POWER;
      CMD_FAST:  btn_act = ACT_FAST;
      CMD_DIR:   btn_act = ACT_NONE;
      default:   btn_act = ACT_RESET;
    endcase
  end

  assign ai      = cmd.axis_idx[AW-1:0];
  assign raw_ext = {{8{raw_store[ai][23]}}, raw_store[ai]};
  assign abs_val = val_r[31] ? (32'd0 - val_r) : val_r;

  always_comb begin
    digit     = '0;
    digit_sub = '0;
    for (int j = 1; j < 10; j++) begin
      if (mag_rem >= digit_weight(cmd.digit_idx, 4'(j))) begin
        digit     = 4'(j);
        digit_sub = digit_weight(cmd.digit_idx, 4'(j));
      end
    end
  end

  assign start_now = !started && ((digit != 4'd0) || (cmd.digit_idx >= SHOW_FROM));

  assign status.btn_hit  = btn_hit;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank        <= BLANK_RESET;
      update_flags <= '0;
      for (int i = 0; i < AXES; i++) begin
        raw_store[i]    <= '0;
        offset_store[i] <= '0;
        dir_neg[i]      <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        blank <= cfg_wdata;
      end
      if (cmd.raw_write && (int'(axis) < AXES)) begin
        raw_store[axis[AW-1:0]] <= raw_sample;
        update_flags[axis]      <= 1'b1;
      end
      if (cmd.start_display) begin
        update_flags <= '0;
      end
      if (cmd.btn_exec && btn_hit) begin
        if (btn_low[1:0] == CMD_DIR) begin
          dir_neg[btn_ax[AW-1:0]] <= !dir_neg[btn_ax[AW-1:0]];
          if (!dir_neg[btn_ax[AW-1:0]]) begin
            offset_store[btn_ax[AW-1:0]] <= offset_store[btn_ax[AW-1:0]] - btn_twice;
          end else begin
            offset_store[btn_ax[AW-1:0]] <= offset_store[btn_ax[AW-1:0]] + btn_twice;
          end
        end else if (btn_low[1:0] == CMD_ZERO) begin
          offset_store[btn_ax[AW-1:0]] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_button) begin
      btn_bits_r <= button_bits;
    end
    if (cmd.btn_exec) begin
      btn_axis_r <= btn_ax;
      btn_act_r  <= btn_act;
    end
    if (cmd.start_display) begin
      mask_r <= update_flags;
    end
    if (cmd.calc_value) begin
      if (dir_neg[ai]) begin
        val_r <= (32'd0 - raw_ext) - offset_store[ai];
      end else begin
        val_r <= raw_ext - offset_store[ai];
      end
    end
    if (cmd.calc_mag) begin
      neg_r    <= val_r[31];
      mag_rem  <= (abs_val > 32'(SAT_LIMIT)) ? SAT_LIMIT : abs_val[16:0];
      started  <= 1'b0;
      sign_pos <= '0;
    end
    if (cmd.digit_step) begin
      mag_rem <= mag_rem - digit_sub;
      if (start_now) begin
        started  <= 1'b1;
        sign_pos <= cmd.digit_idx;
      end
      digs[cmd.digit_idx] <= (started || start_now) ? (DIGIT_ZERO + 8'(digit)) : blank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      if (cmd.emit_button) begin
        result_axis  <= btn_axis_r;
        action       <= btn_act_r;
        shown_value  <= '0;
        char_one     <= '0;
        char_two     <= '0;
        char_three   <= '0;
        char_four    <= '0;
        char_five    <= '0;
        char_six     <= '0;
        updated_mask <= '0;
      end else begin
        result_axis  <= cmd.axis_idx;
        action       <= ACT_NONE;
        shown_value  <= val_r;
        char_one     <= (neg_r && sign_pos == 3'd0) ? MINUS_SIGN : blank;
        char_two     <= (neg_r && sign_pos == 3'd1) ? MINUS_SIGN : digs[0];
        char_three   <= (neg_r && sign_pos == 3'd2) ? MINUS_SIGN : digs[1];
        char_four    <= digs[2];
        char_five    <= digs[3];
        char_six     <= digs[4];
        updated_mask <= mask_r;
      end
    end
  end

  a_hundreds_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.emit_button) |=>
      (char_four >= DIGIT_ZERO && char_four <= DIGIT_ZERO + 8'd9))
    else $error("hundreds position is not a digit");

  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.start_display |=> (update_flags == 4'd0))
    else $error("update flags not cleared by a display request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(shown_value) && $stable(result_axis) && $stable(last)))
    else $error("result word changed while the receiver stalled");

endmodule

### hdl/readout_axis_display_formatter_top.sv
// Top level of the readout axis display formatter.
// Depends on rdf_pkg, rdf_ctrl and rdf_datapath.
//
// Input words arrive on in_valid/in_ready with fields op, axis, raw_sample
// and button_bits; result words leave on out_valid/out_ready. The blank
// character register is written through cfg_we and cfg_wdata.
// A raw update gives no result word. A button event gives one result word
// if any button bit is set and its lowest set bit names an existing axis,
// and none otherwise. A display request gives one word per axis; each axis
// passes through value, magnitude, five digit steps of the shared digit
// unit, and the load of the output register.
// One input word is in work at a time; in_ready is high only while the
// controller is idle, which it may be while the final result word still
// waits in the output register.
// When the receiver stalls, the result word holds in the output register
// and the controller waits before loading the next one.
// Synchronous reset clears all axis stores, the update flags and the
// handshake state, and sets the blank character to a space.
module readout_axis_display_formatter_top import rdf_pkg::*; #(
  parameter int AXES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [1:0]         axis,
  input  logic signed [23:0] raw_sample,
  input  logic [15:0]        button_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_axis,
  output logic [1:0]         action,
  output logic signed [31:0] shown_value,
  output logic [7:0]         char_one,
  output logic [7:0]         char_two,
  output logic [7:0]         char_three,
  output logic [7:0]         char_four,
  output logic [7:0]         char_five,
  output logic [7:0]         char_six,
  output logic [3:0]         updated_mask,
  output logic               last
);

  rdf_cmd_t    cmd;
  rdf_status_t status;

  rdf_ctrl #(.AXES(AXES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  rdf_datapath #(.AXES(AXES)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .axis         (axis),
    .raw_sample   (raw_sample),
    .button_bits  (button_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_axis  (result_axis),
    .action       (action),
    .shown_value  (shown_value),
    .char_one     (char_one),
    .char_two     (char_two),
    .char_three   (char_three),
    .char_four    (char_four),
    .char_five    (char_five),
    .char_six     (char_six),
    .updated_mask (updated_mask),
    .last         (last)
  );

endmodule

### tb/sv/readout_axis_display_formatter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for readout_axis_display_formatter_top. Directed and random raw,
// button and display words are predicted in SystemVerilog and compared with each result word.
// Depends on rdf_pkg and the formatter RTL.
module readout_axis_display_formatter_top_tb import rdf_pkg::*;;

  localparam int NUM_AXES = 4;
  localparam int SETTLE_CYCLES = 48;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [5:0][7:0] display_chars_t;

  typedef struct packed {
    logic [1:0]     axis_id;
    logic [1:0]     act;
    logic [31:0]    value;
    display_chars_t chars;
    logic [3:0]     mask;
    logic           final_word;
  } readout_word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         op;
  logic [1:0]         axis;
  logic signed [23:0] raw_sample;
  logic [15:0]        button_bits;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         result_axis;
  logic [1:0]         action;
  logic signed [31:0] shown_value;
  logic [7:0]         char_one;
  logic [7:0]         char_two;
  logic [7:0]         char_three;
  logic [7:0]         char_four;
  logic [7:0]         char_five;
  logic [7:0]         char_six;
  logic [3:0]         updated_mask;
  logic               last;

  logic signed [31:0] raw_count [NUM_AXES];
  logic [31:0]        zero_offset [NUM_AXES];
  logic               dir_negative [NUM_AXES];
  logic [3:0]         fresh_axes;
  logic [7:0]         blank_code;
  readout_word_t      pending_readouts [$];

  int fault_count = 0;
  int shown_reports = 0;
  int stall_left = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  readout_axis_display_formatter_top #(.AXES(NUM_AXES)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic display_chars_t render_digits(logic [31:0] value);
    int unsigned weight [5] = '{10000, 1000, 100, 10, 1};
    logic [7:0] pos [6];
    display_chars_t packed_chars;
    int unsigned mag;
    int unsigned d;
    bit started;
    int sign_at;
    mag = value[31] ? 32'(32'd0 - value) : value;
    if (mag > SAT_LIMIT) mag = SAT_LIMIT;
    started = 1'b0;
    sign_at = 0;
    pos[0] = blank_code;
    for (int k = 0; k < 5; k++) begin
      d = mag / weight[k];
      mag = mag - d * weight[k];
      if (!started && (d != 0 || k >= 2)) begin
        started = 1'b1;
        sign_at = k;
      end
      pos[k + 1] = started ? DIGIT_ZERO + 8'(d) : blank_code;
    end
    if (value[31]) pos[sign_at] = MINUS_SIGN;
    for (int p = 0; p < 6; p++) packed_chars[5 - p] = pos[p];
    return packed_chars;
  endfunction

  function automatic void predict_readout(logic [1:0] code, logic [1:0] ax,
                                          logic signed [23:0] raw, logic [15:0] btn);
    readout_word_t w;
    int bit_at;
    logic [1:0] cmd;
    logic [31:0] twice;
    w = '0;
    case (code)
      OP_RAW: begin
        raw_count[ax] = {{8{raw[23]}}, raw};
        fresh_axes[ax] = 1'b1;
      end
      OP_BUTTON: begin
        if (btn != '0) begin
          bit_at = 0;
          while (!btn[bit_at]) bit_at++;
          w.axis_id = 2'(bit_at >> 2);
          cmd = 2'(bit_at);
          case (cmd)
            CMD_POWER: w.act = ACT_POWER;
            CMD_FAST: w.act = ACT_FAST;
            CMD_DIR: begin
              twice = raw_count[w.axis_id] * 2;
              dir_negative[w.axis_id] = !dir_negative[w.axis_id];
              if (dir_negative[w.axis_id]) zero_offset[w.axis_id] -= twice;
              else zero_offset[w.axis_id] += twice;
              w.act = ACT_NONE;
            end
            CMD_ZERO: begin
              zero_offset[w.axis_id] = '0;
              w.act = ACT_RESET;
            end
            default: ;
          endcase
          w.final_word = 1'b1;
          pending_readouts.push_back(w);
        end
      end
      OP_DISPLAY: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          w.axis_id = 2'(a);
          w.act = ACT_NONE;
          w.value = (dir_negative[a] ? 32'd0 - raw_count[a] : raw_count[a]) - zero_offset[a];
          w.chars = render_digits(w.value);
          w.mask = fresh_axes;
          w.final_word = (a == NUM_AXES - 1);
          pending_readouts.push_back(w);
        end
        fresh_axes = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(logic [1:0] code, logic [1:0] ax, logic signed [23:0] raw,
                           logic [15:0] btn);
    int gap;
    gap = (!sender_steady && $urandom_range(99) < 37) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    axis <= ax;
    raw_sample <= raw;
    button_bits <= btn;
    do @(posedge clk); while (!in_ready);
    predict_readout(code, ax, raw, btn);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_blank(logic [7:0] code);
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    blank_code = code;
  endtask

  task automatic check_word();
    readout_word_t got;
    readout_word_t want;
    got.axis_id = result_axis;
    got.act = action;
    got.value = shown_value;
    got.chars = {char_one, char_two, char_three, char_four, char_five, char_six};
    got.mask = updated_mask;
    got.final_word = last;
    if (pending_readouts.size() == 0) begin
      fault_count++;
      if (++shown_reports <= 10)
        $display("unexpected word: axis %0d action %0d value %0d chars %h mask %h last %b",
                 got.axis_id, got.act, $signed(got.value), got.chars, got.mask, got.final_word);
      return;
    end
    want = pending_readouts.pop_front();
    if (got !== want) begin
      fault_count++;
      if (++shown_reports <= 10) begin
        $display("mismatch expected: axis %0d action %0d value %0d chars %h mask %h last %b",
                 want.axis_id, want.act, $signed(want.value), want.chars, want.mask,
                 want.final_word);
        $display("         actual:   axis %0d action %0d value %0d chars %h mask %h last %b",
                 got.axis_id, got.act, $signed(got.value), got.chars, got.mask,
                 got.final_word);
      end
    end
  endtask

  function automatic logic signed [23:0] random_raw();
    case ($urandom_range(3))
      0: return 24'(int'($urandom_range(1998)) - 999);
      1: return 24'(int'($urandom_range(199998)) - 99999);
      2: return 24'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_word();
    int pick;
    logic [15:0] noise;
    logic [15:0] btn;
    pick = $urandom_range(99);
    noise = 16'($urandom);
    if (pick < 38) begin
      send_word(OP_RAW, 2'($urandom_range(3)), random_raw(), noise);
    end else if (pick < 70) begin
      if (pick < 62) btn = 16'(1) << $urandom_range(15);
      else if (pick < 68) btn = noise;
      else btn = '0;
      send_word(OP_BUTTON, 2'($urandom_range(3)), random_raw(), btn);
    end else if (pick < 96) begin
      send_word(OP_DISPLAY, 2'($urandom_range(3)), random_raw(), noise);
    end else begin
      send_word(OP_UNUSED, 2'($urandom_range(3)), random_raw(), noise);
    end
  endtask

  task automatic test_reset_display();
    send_word(OP_DISPLAY, 2'd0, '0, '0);
  endtask

  task automatic test_field_extremes();
    send_word(OP_RAW, 2'd0, 24'h7FFFFF, 16'hFFFF);
    send_word(OP_RAW, 2'd1, 24'h800000, '0);
    send_word(OP_RAW, 2'd2, 24'sd7, '0);
    send_word(OP_RAW, 2'd3, -24'sd42, '0);
    send_word(OP_DISPLAY, 2'd3, 24'hFFFFFF, 16'hFFFF);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0001);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0020);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0400);
    send_word(OP_BUTTON, 2'd0, '0, 16'h8000);
    send_word(OP_BUTTON, 2'd3, 24'h7FFFFF, 16'hFFFF);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0000);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0004);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    send_word(OP_UNUSED, 2'd1, 24'h123456, 16'h0001);
    send_word(OP_RAW, 2'd2, -24'sd100000, '0);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0400);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0008);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
  endtask

  task automatic test_blank_character();
    settle_block();
    write_blank(8'h00);
    send_word(OP_RAW, 2'd0, 24'sd100000, '0);
    send_word(OP_RAW, 2'd1, -24'sd5, '0);
    send_word(OP_RAW, 2'd2, 24'sd12345, '0);
    send_word(OP_RAW, 2'd3, -24'sd99999, '0);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0080);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    settle_block();
    write_blank(8'hFF);
    send_word(OP_RAW, 2'd0, 24'sd99999, '0);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    settle_block();
    write_blank(8'($urandom));
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    settle_block();
    write_blank(BLANK_RESET);
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      sender_steady = (i >= count / 3) && (i < count / 3 + 20);
      receiver_steady = sender_steady;
      send_random_word();
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    stall_left = 300;
    sender_steady = 1'b1;
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0002);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    send_word(OP_RAW, 2'd1, random_raw(), '0);
    send_word(OP_BUTTON, 2'd0, '0, 16'h0040);
    send_word(OP_DISPLAY, 2'd0, '0, '0);
    sender_steady = 1'b0;
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_word();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= receiver_steady || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    op <= OP_RAW;
    axis <= '0;
    raw_sample <= '0;
    button_bits <= '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      raw_count[a] = '0;
      zero_offset[a] = '0;
      dir_negative[a] = 1'b0;
    end
    fresh_axes = '0;
    blank_code = BLANK_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_display();
    test_field_extremes();
    test_blank_character();
    test_random_traffic(45);
    settle_block();
    write_blank(8'($urandom));
    test_random_traffic(45);
    test_output_stall();
    settle_block();
    if (fault_count == 0 && pending_readouts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
